@@ hw/rtl/cmaf_pkg.sv @@
package cmaf_pkg;

    localparam int NUM_BUFFERS = 16;
    localparam int IDX_W       = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);
    localparam logic [4:0]       NUM_BUF5 = 5'(NUM_BUFFERS);

    localparam logic [28:0] ID_ALL_ONES = 29'h1FFF_FFFF;

    localparam logic [3:0] OP_INIT     = 4'd0;
    localparam logic [3:0] OP_SET_MASK = 4'd1;
    localparam logic [3:0] OP_SET_DATA = 4'd2;
    localparam logic [3:0] OP_SET_DLC  = 4'd3;
    localparam logic [3:0] OP_RELEASE  = 4'd4;
    localparam logic [3:0] OP_SEND     = 4'd5;
    localparam logic [3:0] OP_TRANSMIT = 4'd6;
    localparam logic [3:0] OP_READ     = 4'd7;
    localparam logic [3:0] OP_RECEIVE  = 4'd8;

    localparam logic [1:0] KIND_DONE   = 2'd0;
    localparam logic [1:0] KIND_BUS    = 2'd1;
    localparam logic [1:0] KIND_NOTIFY = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [1:0] DIR_UNUSED = 2'd0;
    localparam logic [1:0] DIR_RCV    = 2'd1;
    localparam logic [1:0] DIR_TRM    = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [3:0]  operation;
        logic [4:0]  buffer_index;
        logic [28:0] ident;
        logic        extended;
        logic [3:0]  length_code;
        logic [63:0] payload;
        logic [28:0] accept_mask;
        logic        direction;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  buffer_number;
        logic        status;
        logic [28:0] frame_ident;
        logic        frame_extended;
        logic [3:0]  frame_length;
        logic [63:0] frame_data;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [28:0] ident;
        logic        extended;
        logic [3:0]  length;
        logic [63:0] data;
        logic [1:0]  direction;
    } t_entry;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic             wr_mask_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_entry;
        logic [28:0]      wr_mask;
    } t_mem_req;

endpackage

@@ hw/rtl/cmaf_store.sv @@
module cmaf_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cmaf_pkg::t_mem_req i_req,
    output cmaf_pkg::t_entry   o_rd_entry,
    output logic [28:0]        o_rd_mask
);
    import cmaf_pkg::*;

    t_entry           r_mem      [NUM_BUFFERS];
    logic [28:0]      r_mask_mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] r_vld;
    t_entry           r_rd_entry;
    logic [28:0]      r_rd_mask;
    logic             r_rd_vld;

    // contents memory, read-first
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_entry;
        end
        if (i_req.rd_en) begin
            r_rd_entry <= r_mem[i_req.rd_addr];
        end
    end

    // mask memory: no reset, init writes it before any receive can use it
    always_ff @(posedge i_clk) begin
        if (i_req.wr_mask_en) begin
            r_mask_mem[i_req.wr_addr] <= i_req.wr_mask;
        end
        if (i_req.rd_en) begin
            r_rd_mask <= r_mask_mem[i_req.rd_addr];
        end
    end

    // per-entry valid bits stand in for the zero reset of the contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_entry = r_rd_vld ? r_rd_entry : '0;
    assign o_rd_mask  = r_rd_mask;

endmodule

@@ hw/rtl/cmaf_outreg.sv @@
module cmaf_outreg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  cmaf_pkg::t_out_item i_item,
    input  logic               i_stall,
    output logic               o_valid,
    output cmaf_pkg::t_out_item o_item,
    output logic               o_free
);
    import cmaf_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hw/rtl/cmaf_ctrl.sv @@
module cmaf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cmaf_pkg::t_in_item  i_in_item,
    input  cmaf_pkg::t_entry    i_rd_entry,
    input  logic [28:0]         i_rd_mask,
    output cmaf_pkg::t_mem_req  o_req,
    input  logic               i_out_free,
    output logic               o_out_load,
    output cmaf_pkg::t_out_item o_out_item
);
    import cmaf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_OP   = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       r_state, n_state;
    t_in_item         r_item, n_item;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_err, n_err;

    logic [IDX_W-1:0] w_in_addr;
    logic             w_in_bad;
    logic [IDX_W-1:0] w_addr;
    logic [28:0]      w_fid;
    logic [28:0]      w_diff;
    logic             w_hit;
    logic             w_emit;
    t_entry           w_ent;

    function automatic t_out_item bus_frame(t_entry e, logic [4:0] num);
        t_out_item r;
        r                = '0;
        r.kind           = KIND_BUS;
        r.buffer_number  = num;
        r.frame_ident    = e.extended ? e.ident : {18'd0, e.ident[10:0]};
        r.frame_extended = e.extended;
        r.frame_length   = e.length;
        for (int b = 0; b < 8; b++) begin
            if ((e.length >= 4'd8) || (4'(b) < e.length)) begin
                r.frame_data[8*b +: 8] = e.data[8*b +: 8];
            end
        end
        return r;
    endfunction

    function automatic t_out_item contents(t_entry e, logic [1:0] kind, logic [4:0] num);
        t_out_item r;
        r                = '0;
        r.kind           = kind;
        r.buffer_number  = num;
        r.frame_ident    = e.ident;
        r.frame_extended = e.extended;
        r.frame_length   = e.length;
        r.frame_data     = e.data;
        return r;
    endfunction

    assign w_in_addr = IDX_W'(i_in_item.buffer_index - 5'd1);
    assign w_in_bad  = (i_in_item.buffer_index == 5'd0) ||
                       (i_in_item.buffer_index > NUM_BUF5);
    assign w_addr    = IDX_W'(r_item.buffer_index - 5'd1);

    // acceptance compare; a standard frame only looks at the low 11 bits
    assign w_fid  = r_item.extended ? r_item.ident : {18'd0, r_item.ident[10:0]};
    assign w_diff = r_item.extended ? (i_rd_entry.ident ^ w_fid)
                                    : ({18'd0, i_rd_entry.ident[10:0]} ^ w_fid);
    assign w_hit  = i_rd_entry.direction[0] && ((w_diff & i_rd_mask) == 29'd0);

    assign w_emit = (r_item.operation == OP_SEND) || (r_item.operation == OP_TRANSMIT) ||
                    (r_item.operation == OP_READ);

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_idx      = r_idx;
        n_err      = r_err;
        o_req      = '0;
        o_out_load = 1'b0;
        o_out_item = '0;
        w_ent      = i_rd_entry;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    n_err  = STATUS_OK;
                    if (i_in_item.operation == OP_RECEIVE) begin
                        o_req.rd_en   = 1'b1;
                        o_req.rd_addr = '0;
                        n_idx         = '0;
                        n_state       = ST_SCAN;
                    end else if (i_in_item.operation > OP_RECEIVE) begin
                        n_state = ST_DONE;
                    end else if (w_in_bad) begin
                        n_err   = STATUS_ERR;
                        n_state = ST_DONE;
                    end else begin
                        o_req.rd_en   = 1'b1;
                        o_req.rd_addr = w_in_addr;
                        n_state       = ST_OP;
                    end
                end
            end

            ST_OP: begin
                if (!w_emit || i_out_free) begin
                    o_req.wr_addr = w_addr;
                    unique case (r_item.operation)
                        OP_INIT: begin
                            w_ent.ident      = r_item.ident;
                            w_ent.extended   = r_item.extended;
                            w_ent.length     = r_item.length_code;
                            w_ent.direction  = r_item.direction ? DIR_TRM : DIR_RCV;
                            o_req.wr_en      = 1'b1;
                            o_req.wr_mask_en = 1'b1;
                            o_req.wr_mask    = ID_ALL_ONES;
                        end
                        OP_SET_MASK: begin
                            o_req.wr_mask_en = 1'b1;
                            o_req.wr_mask    = r_item.accept_mask;
                        end
                        OP_SET_DATA: begin
                            w_ent.data  = r_item.payload;
                            o_req.wr_en = 1'b1;
                        end
                        OP_SET_DLC: begin
                            w_ent.length = r_item.length_code;
                            o_req.wr_en  = 1'b1;
                        end
                        OP_RELEASE: begin
                            // direction mark and data stay
                            w_ent.ident    = '0;
                            w_ent.extended = 1'b0;
                            w_ent.length   = '0;
                            o_req.wr_en    = 1'b1;
                        end
                        OP_SEND: begin
                            o_out_load = 1'b1;
                            o_out_item = bus_frame(i_rd_entry, r_item.buffer_index);
                        end
                        OP_TRANSMIT: begin
                            w_ent.ident     = r_item.ident;
                            w_ent.extended  = r_item.extended;
                            w_ent.length    = r_item.length_code;
                            w_ent.data      = r_item.payload;
                            w_ent.direction = DIR_TRM;
                            o_req.wr_en     = 1'b1;
                            o_out_load      = 1'b1;
                            o_out_item      = bus_frame(w_ent, r_item.buffer_index);
                        end
                        default: begin
                            o_out_load = 1'b1;
                            o_out_item = contents(i_rd_entry, KIND_READ, r_item.buffer_index);
                        end
                    endcase
                    o_req.wr_entry = w_ent;
                    n_state        = ST_DONE;
                end
            end

            ST_SCAN: begin
                // entry r_idx is on the read port; next read goes out as it retires
                if (!w_hit || i_out_free) begin
                    if (w_hit) begin
                        w_ent.ident    = w_fid;
                        w_ent.extended = r_item.extended;
                        w_ent.length   = r_item.length_code;
                        w_ent.data     = r_item.payload;
                        o_req.wr_en    = 1'b1;
                        o_req.wr_addr  = r_idx;
                        o_req.wr_entry = w_ent;
                        o_out_load     = 1'b1;
                        o_out_item     = contents(w_ent, KIND_NOTIFY, 5'(r_idx) + 5'd1);
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_DONE;
                    end else begin
                        o_req.rd_en   = 1'b1;
                        o_req.rd_addr = r_idx + 1'b1;
                        n_idx         = r_idx + 1'b1;
                    end
                end
            end

            default: begin
                if (i_out_free) begin
                    o_out_load      = 1'b1;
                    o_out_item.kind = KIND_DONE;
                    o_out_item.buffer_number =
                        (r_item.operation == OP_RECEIVE) ? 5'd0 : r_item.buffer_index;
                    o_out_item.status = r_err;
                    o_out_item.last   = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_err   <= STATUS_OK;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |-> i_out_free)
        else $error("result loaded into a full output register");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_req.wr_en || o_req.wr_mask_en) && o_req.rd_en) |-> (o_req.wr_addr != o_req.rd_addr))
        else $error("read and write of one mailbox in the same cycle");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= LAST_IDX))
        else $error("scan index past the last mailbox");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |-> ((o_out_item.kind == KIND_DONE) == o_out_item.last))
        else $error("last flag not on the done result alone");

endmodule

@@ hw/rtl/can_mailbox_acceptance_filter_top.sv @@
// Sequence: a buffer operation passes through the states idle, op and done; a bad index or
//   unknown code goes from idle straight to done; a receive passes idle, scan and done,
//   scanning all NUM_BUFFERS mailboxes with one mailbox memory read per cycle unless stalled.
//   A new item is taken only back in idle, after the done result has been loaded.
// Reset: synchronous active low; mailbox valid bits clear at once, no clearing pass.
module can_mailbox_acceptance_filter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cmaf_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cmaf_pkg::t_out_item o_out_item
);
    import cmaf_pkg::*;

    // Mailbox contents and masks live in two synchronous memories with registered
    // reads inside the store. Contents never written read as all zero through
    // the store's per-entry valid bits, so an unused mailbox has direction 0.
    t_mem_req  w_req;
    t_entry    w_rd_entry;
    logic [28:0] w_rd_mask;

    // Sequencer to output register: one result item per load.
    logic      w_out_load;
    t_out_item w_out_item;
    logic      w_out_free;

    cmaf_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_rd_entry (w_rd_entry),
        .o_rd_mask  (w_rd_mask)
    );

    // The sequencer takes one item at a time. Buffer operations read the
    // addressed mailbox; init, set and release write it back, transmit writes
    // and sends it, send and read only emit it. A receive frame walks the
    // mailboxes in ascending order, one read per cycle, writing back a hit while
    // the next entry is read; it pauses on a hit while the output register is still full.
    cmaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_rd_entry (w_rd_entry),
        .i_rd_mask  (w_rd_mask),
        .o_req      (w_req),
        .i_out_free (w_out_free),
        .o_out_load (w_out_load),
        .o_out_item (w_out_item)
    );

    // Output register decouples the sink's stall from the sequencer.
    cmaf_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_out_load),
        .i_item  (w_out_item),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .o_free  (w_out_free)
    );

endmodule
